/* hdl/erk_pkg.sv */
`default_nettype none
package erk_pkg;
    localparam int unsigned NumTaskSlots = 4;
    localparam int unsigned NumPeriodRegs = 4;
    localparam int unsigned TickW = 32;
    localparam int unsigned IdxW = 3;
    localparam int unsigned PrioW = 3;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned OutDataW = 40;
    localparam logic [TickW-1:0] PeriodReset = 32'd1000;
    localparam int unsigned QueueDepth = 2;

    // Register indexes
    localparam logic [CfgIdxW-1:0] RegPeriod0 = 2'd0;
    localparam logic [CfgIdxW-1:0] RegPeriod1 = 2'd1;
    localparam logic [CfgIdxW-1:0] RegPeriod2 = 2'd2;
    localparam logic [CfgIdxW-1:0] RegPeriod3 = 2'd3;

    typedef logic [TickW-1:0] t_tick;

    // Handshake between queue and back end
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;
endpackage
`default_nettype wire

/* hdl/edf_priority_ranker.sv */
// Result beats for a tick follow one per cycle while m_axis_tready accepts them.
// The bit-serial remainder lanes (one per task) take a new tick only once the previous division is done.
// Each tick yields NUM_TASK_SLOTS result beats; divide, deadline and output run overlapped.
// Reset: synchronous active-low i_rst_n empties the queue and pipeline and sets periods to 1000.
`default_nettype none
module edf_priority_ranker #(
    parameter int unsigned NUM_TASK_SLOTS = erk_pkg::NumTaskSlots
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] tick
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [2:0] task_index, [5:3] priority_res, [37:6] deadline
    output logic        m_axis_tlast
);
    logic [31:0] r_period [erk_pkg::NumPeriodRegs];
    logic [31:0] periods [NUM_TASK_SLOTS];
    erk_pkg::t_hs   q_hs;
    erk_pkg::t_tick q_tick;
    logic q_pop;
    logic [2:0]  task_index, prio;
    logic [31:0] deadline;

    // Period registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < erk_pkg::NumPeriodRegs; i++)
                r_period[i] <= erk_pkg::PeriodReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                erk_pkg::RegPeriod0: r_period[0] <= i_cfg_data;
                erk_pkg::RegPeriod1: r_period[1] <= i_cfg_data;
                erk_pkg::RegPeriod2: r_period[2] <= i_cfg_data;
                erk_pkg::RegPeriod3: r_period[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Slots without a register keep the reset period
    for (genvar g = 0; g < NUM_TASK_SLOTS; g++) begin : g_per
        if (g < erk_pkg::NumPeriodRegs) begin : g_reg
            assign periods[g] = r_period[g];
        end else begin : g_fix
            assign periods[g] = erk_pkg::PeriodReset;
        end
    end

    erk_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_tick     (s_axis_tdata),
        .o_hs_valid (q_hs),
        .i_pop      (q_pop),
        .o_tick     (q_tick)
    );

    erk_core #(.NUM_TASK_SLOTS(NUM_TASK_SLOTS)) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_periods    (periods),
        .i_q_hs       (q_hs),
        .i_q_tick     (q_tick),
        .o_q_pop      (q_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_task_index (task_index),
        .o_priority   (prio),
        .o_deadline   (deadline),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, deadline, prio, task_index};

`ifndef NO_ASSERTIONS
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (task_index == 3'(NUM_TASK_SLOTS-1))))
        else $error("tlast does not match final slot");
    a_run_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("result run broken before last beat");
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");
`endif
endmodule
`default_nettype wire

/* hdl/erk_queue.sv */
`default_nettype none
module erk_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [31:0]      i_tick,
    output erk_pkg::t_hs     o_hs_valid,
    input  wire              i_pop,
    output erk_pkg::t_tick   o_tick
);
    localparam int unsigned Depth = erk_pkg::QueueDepth;
    localparam int unsigned PtrW = $clog2(Depth);

    erk_pkg::t_tick r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [PtrW:0]   r_cnt, n_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != PtrW'(0) + (PtrW+1)'(Depth)) ? 1'b1 : 1'b0;
    assign push = i_valid && o_ready;
    assign pop  = i_pop && (r_cnt != '0);
    assign o_hs_valid.valid = (r_cnt != '0);
    assign o_hs_valid.ready = o_ready;
    assign o_tick = r_mem[r_rd];

    // Track fill level
    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) n_cnt = r_cnt + 1'b1;
        if (pop && !push) n_cnt = r_cnt - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wr <= (r_wr == PtrW'(Depth-1)) ? '0 : r_wr + 1'b1;
            if (pop)  r_rd <= (r_rd == PtrW'(Depth-1)) ? '0 : r_rd + 1'b1;
        end
    end

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_tick;
    end
endmodule
`default_nettype wire

/* hdl/erk_core.sv */
`default_nettype none
module erk_core #(
    parameter int unsigned NUM_TASK_SLOTS = erk_pkg::NumTaskSlots
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire  [31:0]              i_periods [NUM_TASK_SLOTS],
    input  erk_pkg::t_hs             i_q_hs,
    input  erk_pkg::t_tick           i_q_tick,
    output logic                     o_q_pop,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [2:0]               o_task_index,
    output logic [2:0]               o_priority,
    output logic [31:0]              o_deadline,
    output logic                     o_last
);
    localparam int unsigned N = NUM_TASK_SLOTS;
    localparam int unsigned SelW = (N > 1) ? $clog2(N) : 1;

    // Divider stage
    logic        r_a_run, r_a_full;
    logic [4:0]  r_a_cnt;
    logic [31:0] r_a_tick, r_a_shift;
    logic [31:0] r_a_rem [N];
    logic [31:0] r_a_per [N];
    // Deadline stage
    logic        r_b_vld;
    logic [31:0] r_b_dl [N];
    // Result buffer
    logic        r_c_vld;
    logic [SelW-1:0] r_c_sel;
    logic [31:0] r_c_dl [N];
    logic [2:0]  r_c_prio [N];

    logic a_start, a_go, b_go, load_out, c_go;
    logic [31:0] dl_calc [N];
    logic [2:0]  prio_calc [N];

    assign load_out = r_c_vld && (!o_valid || i_ready);
    assign c_go     = load_out && (r_c_sel == SelW'(N-1));
    assign b_go     = r_b_vld && (!r_c_vld || c_go);
    assign a_go     = r_a_full && (!r_b_vld || b_go);
    assign a_start  = i_q_hs.valid && !r_a_run && (!r_a_full || a_go);
    assign o_q_pop  = a_start;

    // Remainder lanes, one quotient bit per cycle
    for (genvar g = 0; g < N; g++) begin : g_lane
        logic [32:0] rs;
        assign rs = {r_a_rem[g], r_a_shift[31]};
        always_ff @(posedge i_clk) begin
            if (a_start) begin
                r_a_rem[g] <= '0;
                r_a_per[g] <= i_periods[g];
            end else if (r_a_run) begin
                if (rs >= {1'b0, r_a_per[g]}) r_a_rem[g] <= 32'(rs - {1'b0, r_a_per[g]});
                else                          r_a_rem[g] <= rs[31:0];
            end
        end
        // Deadline is the tick rounded down to a multiple, plus one period; a zero period gives zero
        assign dl_calc[g] = (r_a_per[g] == '0) ? '0 : r_a_tick - r_a_rem[g] + r_a_per[g];
    end

    // Rank: count the slots that come earlier
    always_comb begin
        for (int i = 0; i < N; i++) begin
            logic [3:0] earlier;
            earlier = '0;
            for (int j = 0; j < N; j++) begin
                if (r_b_dl[j] < r_b_dl[i] || (r_b_dl[j] == r_b_dl[i] && j < i))
                    earlier = earlier + 1'b1;
            end
            prio_calc[i] = 3'(4'(N-1) - earlier);
        end
    end

    // Divider control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_run  <= 1'b0;
            r_a_full <= 1'b0;
            r_a_cnt  <= '0;
        end else begin
            if (a_go) r_a_full <= 1'b0;
            if (a_start) begin
                r_a_run <= 1'b1;
                r_a_cnt <= '0;
            end else if (r_a_run) begin
                r_a_cnt <= r_a_cnt + 1'b1;
                if (r_a_cnt == 5'd31) begin
                    r_a_run  <= 1'b0;
                    r_a_full <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_start) begin
            r_a_tick  <= i_q_tick;
            r_a_shift <= i_q_tick;
        end else if (r_a_run) begin
            r_a_shift <= {r_a_shift[30:0], 1'b0};
        end
    end

    // Stage valids and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_c_sel <= '0;
            o_valid <= 1'b0;
        end else begin
            if (a_go) r_b_vld <= 1'b1;
            else if (b_go) r_b_vld <= 1'b0;
            if (b_go) begin
                r_c_vld <= 1'b1;
                r_c_sel <= '0;
            end else if (c_go) begin
                r_c_vld <= 1'b0;
            end else if (load_out) begin
                r_c_sel <= r_c_sel + 1'b1;
            end
            if (load_out) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (a_go) r_b_dl <= dl_calc;
        if (b_go) begin
            r_c_dl   <= r_b_dl;
            r_c_prio <= prio_calc;
        end
        if (load_out) begin
            o_task_index <= 3'(r_c_sel);
            o_priority   <= r_c_prio[r_c_sel];
            o_deadline   <= r_c_dl[r_c_sel];
            o_last       <= (r_c_sel == SelW'(N-1));
        end
    end
endmodule
`default_nettype wire

/* test/tb.sv */
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NumSlots = erk_pkg::NumTaskSlots;
    localparam int unsigned IdxW     = erk_pkg::IdxW;
    localparam int unsigned PrioW    = erk_pkg::PrioW;
    localparam int unsigned CfgIdxW  = erk_pkg::CfgIdxW;

    typedef erk_pkg::t_tick t_tick;

    typedef struct {
        logic [IdxW-1:0]  task_idx;
        logic [PrioW-1:0] prio;
        t_tick            deadline;
        logic             last;
    } t_rank;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    t_tick  tick_q[$];
    t_rank  rank_q[$];
    t_tick  periods[NumSlots];
    int     send_idle_pct;
    int     recv_idle_pct;
    int     err_cnt;
    logic   in_taken;

    edf_priority_ranker u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    // Clock, 20 ns period
    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Next absolute deadline of one task, wrapped to 32 bits
    function automatic t_tick next_deadline(input t_tick tick, input t_tick period);
        logic [63:0] base;
        if (period == '0) begin
            return '0;
        end
        base = 64'(tick / period) * 64'(period) + 64'(period);
        return base[31:0];
    endfunction

    // Rank all tasks for one tick and queue the expected beats
    task automatic push_ranking(input t_tick tick);
        t_tick dl[NumSlots];
        int    earlier;
        t_rank r;
        for (int i = 0; i < NumSlots; i++) begin
            dl[i] = next_deadline(tick, periods[i]);
        end
        for (int i = 0; i < NumSlots; i++) begin
            earlier = 0;
            for (int j = 0; j < NumSlots; j++) begin
                if (dl[j] < dl[i] || (dl[j] == dl[i] && j < i)) begin
                    earlier++;
                end
            end
            r.task_idx = IdxW'(i);
            r.prio     = PrioW'(NumSlots - 1 - earlier);
            r.deadline = dl[i];
            r.last     = (i == NumSlots - 1);
            rank_q.push_back(r);
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("tb: mismatch %s got %0h want %0h", what, got, want);
        err_cnt++;
    endtask

    // Input side: record each accepted beat and its expected results
    always @(posedge clk) begin
        in_taken = rst_n && s_tvalid && s_tready;
        if (in_taken) begin
            push_ranking(s_tdata);
            void'(tick_q.pop_front());
        end
    end

    // Driver: present queued ticks, idle at random
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // hold the beat
        end else begin
            if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= tick_q[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge clk) begin
        t_rank w;
        if (rst_n && m_tvalid && m_tready) begin
            if (rank_q.size() == 0) begin
                report("unexpected beat", 64'(m_tdata), 64'(0));
            end else begin
                w = rank_q.pop_front();
                if (m_tdata[2:0] !== w.task_idx)
                    report("task_index", 64'(m_tdata[2:0]), 64'(w.task_idx));
                if (m_tdata[5:3] !== w.prio)
                    report("priority", 64'(m_tdata[5:3]), 64'(w.prio));
                if (m_tdata[37:6] !== w.deadline)
                    report("deadline", 64'(m_tdata[37:6]), 64'(w.deadline));
                if (m_tlast !== w.last)
                    report("tlast", 64'(m_tlast), 64'(w.last));
            end
        end
    end

    task automatic write_period(input logic [CfgIdxW-1:0] idx, input t_tick value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        if (idx < NumSlots) begin
            periods[idx] = value;
        end
    endtask

    // Wait until every tick is taken and every ranking has arrived
    task automatic drain();
        while (tick_q.size() > 0 || s_tvalid || rank_q.size() > 0) begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    function automatic t_tick rand_period();
        case ($urandom_range(5))
            0: return t_tick'($urandom_range(1, 8));
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000 + $urandom_range(0, 1000);
            3: return t_tick'($urandom_range(1, 5000));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_tick rand_tick();
        case ($urandom_range(3))
            0: return t_tick'($urandom_range(0, 3000));
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3000);
            default: return $urandom;
        endcase
    endfunction

    // Stimulus
    initial begin
        logic [CfgIdxW-1:0] regs[4];
        regs = '{erk_pkg::RegPeriod0, erk_pkg::RegPeriod1,
                 erk_pkg::RegPeriod2, erk_pkg::RegPeriod3};
        err_cnt       = 0;
        send_idle_pct = 36;
        recv_idle_pct = 82;
        in_taken = 1'b0;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        for (int i = 0; i < NumSlots; i++) periods[i] = erk_pkg::PeriodReset;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset periods, tick extremes, equal deadlines
        tick_q = '{32'd0, 32'd999, 32'd1000, 32'hFFFF_FFFF, 32'hAAAA_5555};
        drain();
        // Zero period, tiny period, and a wrapping deadline
        write_period(erk_pkg::RegPeriod0, 32'd0);
        write_period(erk_pkg::RegPeriod1, 32'd1);
        write_period(erk_pkg::RegPeriod2, 32'hFFFF_FFFF);
        write_period(erk_pkg::RegPeriod3, 32'h8000_0001);
        tick_q = '{32'd0, 32'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'h8000_0001, 32'h5555_AAAA};
        drain();
        // All periods equal: ties resolve by task index
        for (int i = 0; i < 4; i++) write_period(regs[i], 32'd7);
        tick_q = '{32'd6, 32'd7, 32'hFFFF_FFFB, 32'hFFFF_FFFF};
        drain();

        // Random phases with changing periods and idling profiles
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 82;
                recv_idle_pct = 36;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 4; i++) write_period(regs[i], rand_period());
            for (int k = 0; k < 26; k++) tick_q.push_back(rand_tick());
            drain();
        end

        if (err_cnt == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Timeout guard
    initial begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

/* edf_priority_ranker.f */
hdl/erk_pkg.sv
hdl/erk_queue.sv
hdl/erk_core.sv
hdl/edf_priority_ranker.sv
test/tb.sv
